// ===== hw/rtl/soa_pkg.sv =====
package soa_pkg;

  localparam int FRAME_BYTES  = 4096;
  localparam int NUM_FRAMES   = 16;
  localparam int HEADER_BYTES = 48;
  localparam int NUM_CLASSES  = 9;

  localparam int FB_LOG      = $clog2(FRAME_BYTES);
  localparam int FIW         = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FW          = $clog2(NUM_FRAMES + 1);
  localparam int SPAN        = FRAME_BYTES - HEADER_BYTES;
  localparam int MAX_SLOTS   = SPAN / 8;
  localparam int SW          = $clog2(MAX_SLOTS + 1);
  localparam int STACK_DEPTH = NUM_FRAMES << SW;
  localparam int AW          = FIW + SW;
  localparam int CLS_IW      = $clog2(NUM_CLASSES + 1);

  typedef logic [FW-1:0]  frame_t;
  typedef logic [FIW-1:0] fidx_t;
  typedef logic [SW-1:0]  slot_t;
  typedef logic [3:0]     cls_t;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SIZE    = 3'd1,
    ST_NO_FRAME    = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_SET_ERR, CMD_EMIT,
    CMD_A_START, CMD_A_HOP, CMD_A_CLAIM, CMD_A_FILL, CMD_A_POP, CMD_A_ADDR,
    CMD_F_SEL, CMD_F_START, CMD_F_READ, CMD_F_NEXT, CMD_F_PUSH,
    CMD_S_START, CMD_S_HEAD, CMD_S_STEP, CMD_S_NEXTC
  } cmd_e;

  typedef struct packed {
    cmd_e    op;
    status_e code;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic bad_class;
    logic walk_live;
    logic cur_no_space;
    logic has_space;
    logic free_avail;
    logic fill_last;
    logic free_bad;
    logic scan_done;
    logic scan_hit;
    logic push_full;
    logic last_class;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [3:0] {
    SM_IDLE, SM_DECODE, SM_A_WALK, SM_A_FILL, SM_A_POP, SM_A_ADDR,
    SM_F_CHK, SM_F_LOOP, SM_F_CMP, SM_F_PUSH, SM_S_HEAD, SM_S_WALK, SM_EMIT
  } state_e;

  function automatic logic [11:0] class_bytes_f(cls_t c);
    return 12'(32'd8 << c);
  endfunction

  function automatic slot_t slots_f(cls_t c);
    return SW'(SPAN >> (c + 4'd3));
  endfunction

  function automatic cls_t class_for(logic [15:0] size);
    cls_t r;
    r = cls_t'(NUM_CLASSES);
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if ({1'b0, size} <= 17'(32'd8 << k)) r = cls_t'(k);
    end
    if (size == 16'd0) r = cls_t'(NUM_CLASSES);
    return r;
  endfunction

endpackage

// ===== hw/rtl/soa_if.sv =====
interface soa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] size;
  logic [15:0] address;
  modport source (output valid, op, size, address, input ready);
  modport sink (input valid, op, size, address, output ready);
endinterface

interface soa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] object_address;
  logic [3:0]  size_class;
  logic [11:0] class_bytes;
  logic [4:0]  frames_released;
  modport source (output valid, status, object_address, size_class, class_bytes,
                  frames_released, input ready);
  modport sink (input valid, status, object_address, size_class, class_bytes,
                frames_released, output ready);
endinterface

// ===== hw/rtl/soa_ctrl.sv =====
module soa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  soa_pkg::dp_status_t st_i,
  output soa_pkg::cmd_t       cmd_o
);
  import soa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    cmd_o.code = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      SM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_LATCH;
          state_d  = SM_DECODE;
        end
      end
      SM_DECODE: begin
        unique case (st_i.op) inside
          OP_ALLOC, OP_FREE: begin
            if (st_i.bad_class) begin
              cmd_o.op   = CMD_SET_ERR;
              cmd_o.code = ST_BAD_SIZE;
              state_d    = SM_EMIT;
            end else if (st_i.op == OP_ALLOC) begin
              cmd_o.op = CMD_A_START;
              state_d  = SM_A_WALK;
            end else begin
              cmd_o.op = CMD_F_SEL;
              state_d  = SM_F_CHK;
            end
          end
          OP_SHRINK: begin
            cmd_o.op = CMD_S_START;
            state_d  = SM_S_HEAD;
          end
          default: state_d = SM_EMIT;
        endcase
      end
      SM_A_WALK: begin
        if (st_i.walk_live && st_i.cur_no_space) begin
          cmd_o.op = CMD_A_HOP;
        end else if (st_i.has_space) begin
          state_d = SM_A_POP;
        end else if (st_i.free_avail) begin
          cmd_o.op = CMD_A_CLAIM;
          state_d  = SM_A_FILL;
        end else begin
          cmd_o.op   = CMD_SET_ERR;
          cmd_o.code = ST_NO_FRAME;
          state_d    = SM_EMIT;
        end
      end
      SM_A_FILL: begin
        cmd_o.op = CMD_A_FILL;
        if (st_i.fill_last) state_d = SM_A_POP;
      end
      SM_A_POP: begin
        cmd_o.op = CMD_A_POP;
        state_d  = SM_A_ADDR;
      end
      SM_A_ADDR: begin
        cmd_o.op = CMD_A_ADDR;
        state_d  = SM_EMIT;
      end
      SM_F_CHK: begin
        if (st_i.free_bad) begin
          cmd_o.op   = CMD_SET_ERR;
          cmd_o.code = ST_NOT_FOUND;
          state_d    = SM_EMIT;
        end else begin
          cmd_o.op = CMD_F_START;
          state_d  = SM_F_LOOP;
        end
      end
      SM_F_LOOP: begin
        if (st_i.scan_done) begin
          state_d = SM_F_PUSH;
        end else begin
          cmd_o.op = CMD_F_READ;
          state_d  = SM_F_CMP;
        end
      end
      SM_F_CMP: begin
        if (st_i.scan_hit) begin
          cmd_o.op   = CMD_SET_ERR;
          cmd_o.code = ST_DOUBLE_FREE;
          state_d    = SM_EMIT;
        end else begin
          cmd_o.op = CMD_F_NEXT;
          state_d  = SM_F_LOOP;
        end
      end
      SM_F_PUSH: begin
        if (st_i.push_full) begin
          cmd_o.op   = CMD_SET_ERR;
          cmd_o.code = ST_DOUBLE_FREE;
        end else begin
          cmd_o.op = CMD_F_PUSH;
        end
        state_d = SM_EMIT;
      end
      SM_S_HEAD: begin
        cmd_o.op = CMD_S_HEAD;
        state_d  = SM_S_WALK;
      end
      SM_S_WALK: begin
        if (st_i.walk_live) begin
          cmd_o.op = CMD_S_STEP;
        end else if (st_i.last_class) begin
          state_d = SM_EMIT;
        end else begin
          cmd_o.op = CMD_S_NEXTC;
          state_d  = SM_S_HEAD;
        end
      end
      SM_EMIT: begin
        if (!st_i.out_busy) begin
          cmd_o.op = CMD_EMIT;
          state_d  = SM_IDLE;
        end
      end
      default: state_d = SM_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == SM_DECODE))
    else $error("accepted word not decoded");
`endif

endmodule

// ===== hw/rtl/soa_dp.sv =====
module soa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  soa_pkg::cmd_t       cmd_i,
  output soa_pkg::dp_status_t st_o,
  input  logic [1:0]          in_op_i,
  input  logic [15:0]         in_size_i,
  input  logic [15:0]         in_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          out_status_o,
  output logic [15:0]         out_object_address_o,
  output logic [3:0]          out_size_class_o,
  output logic [11:0]         out_class_bytes_o,
  output logic [4:0]          out_frames_released_o
);
  import soa_pkg::*;

  // working registers
  op_e         op_q;
  cls_t        cls_q;
  logic [15:0] addr_q;
  frame_t      cur_q, prev_q, hops_q;
  logic        kept_q;
  slot_t       idx_q, cnt_q, slot_q;
  status_e     st_q;
  logic [15:0] obj_q;
  logic [4:0]  rel_q;

  // per-frame and per-class state
  logic [NUM_FRAMES-1:0] in_use_q;
  cls_t   fclass_q [NUM_FRAMES];
  frame_t fnext_q  [NUM_FRAMES];
  slot_t  fcount_q [NUM_FRAMES];
  frame_t head_q   [NUM_CLASSES];

  // free slot stacks
  slot_t  stack_mem [STACK_DEPTH];
  slot_t  rd_q;
  logic   mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  slot_t  mem_wd;

  // result register
  logic        ovalid_q;
  status_e     o_status_q;
  logic [15:0] o_obj_q;
  cls_t        o_cls_q;
  logic [11:0] o_bytes_q;
  logic [4:0]  o_rel_q;

  fidx_t  cf, pf, ff;
  logic [CLS_IW-1:0] ci;
  logic   cur_lt, prev_lt, free_avail, release_c;
  slot_t  fc_cur, n_cls;
  frame_t nx;
  logic [FB_LOG-1:0] off, dlt, amask, slot_full;
  logic [15:0] fr_full;

  assign cf      = cur_q[FIW-1:0];
  assign pf      = prev_q[FIW-1:0];
  assign ci      = cls_q[CLS_IW-1:0];
  assign cur_lt  = cur_q < FW'(NUM_FRAMES);
  assign prev_lt = prev_q < FW'(NUM_FRAMES);
  assign fc_cur  = fcount_q[cf];
  assign n_cls   = slots_f(cls_q);
  assign nx      = fnext_q[cf];
  assign release_c = (fc_cur == n_cls) && kept_q;

  always_comb begin
    free_avail = 1'b0;
    ff         = '0;
    for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_avail = 1'b1;
        ff         = FIW'(k);
      end
    end
  end

  // free address decode
  assign fr_full   = addr_q >> FB_LOG;
  assign off       = addr_q[FB_LOG-1:0];
  assign dlt       = off - FB_LOG'(HEADER_BYTES);
  assign amask     = FB_LOG'((32'd8 << cls_q) - 32'd1);
  assign slot_full = dlt >> (cls_q + 4'd3);

  always_comb begin
    st_o.op           = op_q;
    st_o.bad_class    = cls_q >= cls_t'(NUM_CLASSES);
    st_o.walk_live    = cur_lt && (hops_q < FW'(NUM_FRAMES));
    st_o.cur_no_space = fc_cur == '0;
    st_o.has_space    = cur_lt && (fc_cur != '0);
    st_o.free_avail   = free_avail;
    st_o.fill_last    = idx_q == (n_cls - SW'(1));
    st_o.free_bad     = !cur_lt || !in_use_q[cf] || (fclass_q[cf] != cls_q) ||
                        (off < FB_LOG'(HEADER_BYTES)) || ((dlt & amask) != '0) ||
                        (slot_full >= FB_LOG'(n_cls));
    st_o.scan_done    = idx_q == cnt_q;
    st_o.scan_hit     = rd_q == slot_q;
    st_o.push_full    = cnt_q >= n_cls;
    st_o.last_class   = cls_q == cls_t'(NUM_CLASSES - 1);
    st_o.out_busy     = ovalid_q && !out_ready_i;
  end

  // stack port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {cf, idx_q};
    mem_wd = n_cls - SW'(1) - idx_q;
    mem_ra = {cf, idx_q};
    case (cmd_i.op)
      CMD_A_FILL: mem_we = 1'b1;
      CMD_A_POP:  mem_ra = {cf, fc_cur - SW'(1)};
      CMD_F_PUSH: begin
        mem_we = 1'b1;
        mem_wa = {cf, cnt_q};
        mem_wd = slot_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    rd_q <= stack_mem[mem_ra];
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      ovalid_q <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) head_q[k] <= frame_t'(NUM_FRAMES);
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (cmd_i.op)
        CMD_A_CLAIM: begin
          in_use_q[ff] <= 1'b1;
          head_q[ci]   <= FW'(ff);
        end
        CMD_S_STEP: begin
          if (release_c) begin
            in_use_q[cf] <= 1'b0;
            if (!prev_lt) head_q[ci] <= nx;
          end
        end
        CMD_EMIT: ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LATCH: begin
        op_q   <= op_e'(in_op_i);
        cls_q  <= class_for(in_size_i);
        addr_q <= in_address_i;
        st_q   <= ST_OK;
        obj_q  <= '0;
        rel_q  <= '0;
      end
      CMD_SET_ERR: st_q <= cmd_i.code;
      CMD_A_START: begin
        cur_q  <= head_q[ci];
        hops_q <= '0;
      end
      CMD_A_HOP: begin
        cur_q  <= nx;
        hops_q <= hops_q + FW'(1);
      end
      CMD_A_CLAIM: begin
        fclass_q[ff] <= cls_q;
        fcount_q[ff] <= n_cls;
        fnext_q[ff]  <= head_q[ci];
        cur_q        <= FW'(ff);
        idx_q        <= '0;
      end
      CMD_A_FILL: idx_q <= idx_q + SW'(1);
      CMD_A_POP:  fcount_q[cf] <= fc_cur - SW'(1);
      CMD_A_ADDR: obj_q <= 16'((32'(cur_q) << FB_LOG) + 32'(HEADER_BYTES) +
                               (32'(rd_q) << (cls_q + 4'd3)));
      CMD_F_SEL: begin
        if (fr_full < 16'(NUM_FRAMES)) cur_q <= FW'(fr_full);
        else cur_q <= frame_t'(NUM_FRAMES);
      end
      CMD_F_START: begin
        cnt_q  <= fc_cur;
        idx_q  <= '0;
        slot_q <= SW'(slot_full);
      end
      CMD_F_NEXT: idx_q <= idx_q + SW'(1);
      CMD_F_PUSH: fcount_q[cf] <= cnt_q + SW'(1);
      CMD_S_START: begin
        cls_q <= '0;
        rel_q <= '0;
      end
      CMD_S_HEAD: begin
        cur_q  <= head_q[ci];
        prev_q <= frame_t'(NUM_FRAMES);
        hops_q <= '0;
        kept_q <= 1'b0;
      end
      CMD_S_STEP: begin
        if (release_c) begin
          if (prev_lt) fnext_q[pf] <= nx;
          if (rel_q != 5'd31) rel_q <= rel_q + 5'd1;
        end else begin
          if (fc_cur == n_cls) kept_q <= 1'b1;
          prev_q <= cur_q;
        end
        cur_q  <= nx;
        hops_q <= hops_q + FW'(1);
      end
      CMD_S_NEXTC: cls_q <= cls_q + 4'd1;
      CMD_EMIT: begin
        o_status_q <= st_q;
        o_obj_q    <= obj_q;
        o_rel_q    <= rel_q;
        if ((op_q == OP_ALLOC || op_q == OP_FREE) && cls_q < cls_t'(NUM_CLASSES)) begin
          o_cls_q   <= cls_q;
          o_bytes_q <= class_bytes_f(cls_q);
        end else begin
          o_cls_q   <= '0;
          o_bytes_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o           = ovalid_q;
  assign out_status_o          = o_status_q;
  assign out_object_address_o  = o_obj_q;
  assign out_size_class_o      = o_cls_q;
  assign out_class_bytes_o     = o_bytes_q;
  assign out_frames_released_o = o_rel_q;

`ifndef SYNTHESIS
  a_hops_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_A_HOP || cmd_i.op == CMD_S_STEP) |-> (hops_q < FW'(NUM_FRAMES)))
    else $error("list walk overran frame count");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_EMIT) |-> !(ovalid_q && !out_ready_i))
    else $error("result overwritten while held");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (o_status_q <= ST_DOUBLE_FREE))
    else $error("status code out of range");
`endif

endmodule

// ===== hw/rtl/slab_object_allocator_core.sv =====
// Alloc walks the class list from its head, hop by hop, past frames with no free slot;
//   claiming a new frame first builds its stack, one slot of its class (up to 506) at a time.
// Free scans every entry on the frame's free stack for the slot (double-free scan).
// Shrink walks the list of every class, frame by frame. The result waits while the output is held.
// One word in flight; the next word is taken only after the result has loaded.
// Reset clears frame ownership, class lists and the output valid; no clearing pass.
module slab_object_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  soa_req_if.sink     req_i,
  soa_rsp_if.source   rsp_o
);
  import soa_pkg::*;

  cmd_t       cmd;
  dp_status_t st;

  // Sequencer: walks class lists, fills and scans the per-frame slot stacks.
  soa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: frame tables, stack memory, address math and the result register.
  soa_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .st_o                  (st),
    .in_op_i               (req_i.op),
    .in_size_i             (req_i.size),
    .in_address_i          (req_i.address),
    .out_valid_o           (rsp_o.valid),
    .out_ready_i           (rsp_o.ready),
    .out_status_o          (rsp_o.status),
    .out_object_address_o  (rsp_o.object_address),
    .out_size_class_o      (rsp_o.size_class),
    .out_class_bytes_o     (rsp_o.class_bytes),
    .out_frames_released_o (rsp_o.frames_released)
  );

endmodule

// ===== tb/slab_object_allocator_core_tb.sv =====
`timescale 1ns / 1ps

module slab_object_allocator_core_tb;
  import soa_pkg::*;

  // one request word plus a flag that holds the driver until the block drains
  typedef struct {
    logic [1:0]  op;
    logic [15:0] size;
    logic [15:0] address;
    bit          drain;
  } req_word_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] object_address;
    logic [3:0]  size_class;
    logic [11:0] class_bytes;
    logic [4:0]  frames_released;
  } rsp_word_t;

  logic clk_i;
  logic rst_ni;

  soa_req_if req ();
  soa_rsp_if rsp ();

  slab_object_allocator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // shadow allocator state
  bit frame_used [NUM_FRAMES];
  int frame_cls  [NUM_FRAMES];
  int frame_link [NUM_FRAMES];
  int list_head  [NUM_CLASSES];
  int slots_free [NUM_FRAMES];
  int slot_stack [NUM_FRAMES][MAX_SLOTS];

  req_word_t pending_words[$];
  rsp_word_t expected_rsps[$];
  int        words_sent;
  int        rsps_seen;
  int        fail_count;

  // live and recently released objects, steers frees and double frees
  logic [15:0] live_addr[$];
  logic [15:0] live_size[$];
  logic [15:0] gone_addr[$];
  logic [15:0] gone_size[$];

  function automatic rsp_word_t slab_predict(logic [1:0] op, logic [15:0] size,
                                             logic [15:0] addr);
    rsp_word_t r;
    int c, f, hops, n, sz, slot, off, cnt, prev, nx, released;
    bit kept, empty;
    r = '{default: '0};
    if (op == OP_ALLOC || op == OP_FREE) begin
      c = NUM_CLASSES;
      if (size != 0) begin
        for (int k = NUM_CLASSES - 1; k >= 0; k--) if (size <= (8 << k)) c = k;
      end
      if (c >= NUM_CLASSES) begin
        r.status = ST_BAD_SIZE;
      end else begin
        sz = 8 << c;
        n = SPAN / sz;
        r.size_class = 4'(c);
        r.class_bytes = 12'(sz);
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
          f = list_head[c];
          hops = 0;
          while (f < NUM_FRAMES && hops < NUM_FRAMES && slots_free[f] == 0) begin
            f = frame_link[f];
            hops++;
          end
          if (!(f < NUM_FRAMES && slots_free[f] != 0)) begin
            for (f = 0; f < NUM_FRAMES; f++) if (!frame_used[f]) break;
            if (f >= NUM_FRAMES) begin
              r.status = ST_NO_FRAME;
            end else begin
              frame_used[f] = 1'b1;
              frame_cls[f] = c;
              slots_free[f] = n;
              for (int i = 0; i < n; i++) slot_stack[f][i] = n - 1 - i;
              frame_link[f] = list_head[c];
              list_head[c] = f;
            end
          end
          if (r.status == ST_OK) begin
            slots_free[f]--;
            slot = slot_stack[f][slots_free[f]];
            r.object_address = 16'(f * FRAME_BYTES + HEADER_BYTES + slot * sz);
          end
        end else begin
          f = addr / FRAME_BYTES;
          off = addr % FRAME_BYTES;
          if (f >= NUM_FRAMES || !frame_used[f] || frame_cls[f] != c ||
              off < HEADER_BYTES || (off - HEADER_BYTES) % sz != 0 ||
              (off - HEADER_BYTES) / sz >= n) begin
            r.status = ST_NOT_FOUND;
          end else begin
            slot = (off - HEADER_BYTES) / sz;
            cnt = slots_free[f];
            for (int i = 0; i < cnt; i++) if (slot_stack[f][i] == slot) r.status = ST_DOUBLE_FREE;
            if (cnt >= n) r.status = ST_DOUBLE_FREE;
            if (r.status == ST_OK) begin
              slot_stack[f][cnt] = slot;
              slots_free[f] = cnt + 1;
            end
          end
        end
      end
    end else if (op == OP_SHRINK) begin
      released = 0;
      for (c = 0; c < NUM_CLASSES; c++) begin
        f = list_head[c];
        prev = NUM_FRAMES;
        hops = 0;
        kept = 1'b0;
        while (f < NUM_FRAMES && hops < NUM_FRAMES) begin
          nx = frame_link[f];
          empty = (slots_free[f] == SPAN / (8 << c));
          if (empty && kept) begin
            if (prev < NUM_FRAMES) frame_link[prev] = nx;
            else list_head[c] = nx;
            frame_used[f] = 1'b0;
            released++;
          end else begin
            if (empty) kept = 1'b1;
            prev = f;
          end
          f = nx;
          hops++;
        end
      end
      r.frames_released = 5'((released > 31) ? 31 : released);
    end
    return r;
  endfunction

  // predict, queue the word and its result, and keep the object lists current
  task automatic push_word(logic [1:0] op, logic [15:0] size, logic [15:0] addr);
    rsp_word_t r;
    r = slab_predict(op, size, addr);
    pending_words.push_back('{op: op, size: size, address: addr, drain: 1'b0});
    expected_rsps.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) begin
      for (int i = gone_addr.size() - 1; i >= 0; i--) begin
        if (gone_addr[i] == r.object_address) begin
          gone_addr.delete(i);
          gone_size.delete(i);
        end
      end
      live_addr.push_back(r.object_address);
      live_size.push_back(size);
    end
    if (op == OP_FREE && r.status == ST_OK) begin
      for (int i = live_addr.size() - 1; i >= 0; i--) begin
        if (live_addr[i] == addr) begin
          live_addr.delete(i);
          live_size.delete(i);
        end
      end
      gone_addr.push_back(addr);
      gone_size.push_back(size);
      if (gone_addr.size() > 32) begin
        gone_addr.delete(0);
        gone_size.delete(0);
      end
    end
  endtask

  function automatic logic [15:0] size_in_class(int c);
    return (c == 0) ? 16'($urandom_range(1, 8)) : 16'($urandom_range((4 << c) + 1, 8 << c));
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid   <= 1'b0;
      req.op      <= '0;
      req.size    <= '0;
      req.address <= '0;
      send_gap    <= 0;
    end else begin
      if (req.valid && req.ready) words_sent <= words_sent + 1;
      if (!req.valid || req.ready) begin
        if (req.valid && req.ready) begin
          send_gap <= pick_gap();
          req.valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_words.size() > 0 && pending_words[0].drain) begin
          // hold off until the block has answered everything
          if (words_sent == rsps_seen) void'(pending_words.pop_front());
          req.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          req.valid   <= 1'b1;
          req.op      <= pending_words[0].op;
          req.size    <= pending_words[0].size;
          req.address <= pending_words[0].address;
          void'(pending_words.pop_front());
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor with random backpressure
  int stall;
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_word_t e;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      stall     <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsps_seen <= rsps_seen + 1;
        if (expected_rsps.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, rsp.status);
            fail_count++;
          end
          if (rsp.object_address !== e.object_address) begin
            $error("object_address expected %0h got %0h", e.object_address,
                   rsp.object_address);
            fail_count++;
          end
          if (rsp.size_class !== e.size_class) begin
            $error("size_class expected %0d got %0d", e.size_class, rsp.size_class);
            fail_count++;
          end
          if (rsp.class_bytes !== e.class_bytes) begin
            $error("class_bytes expected %0d got %0d", e.class_bytes, rsp.class_bytes);
            fail_count++;
          end
          if (rsp.frames_released !== e.frames_released) begin
            $error("frames_released expected %0d got %0d", e.frames_released,
                   rsp.frames_released);
            fail_count++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        rsp.ready <= 1'b0;
      end else begin
        stall <= pick_gap();
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int p, c, k;
    logic [15:0] a, s;
    words_sent = 0;
    rsps_seen  = 0;
    fail_count = 0;
    for (int f = 0; f < NUM_FRAMES; f++) frame_used[f] = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) list_head[i] = NUM_FRAMES;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: size edges, bad sizes, each kind of bad free, double free, op 3, shrink
    push_word(OP_ALLOC, 16'd1, 16'd0);
    push_word(OP_ALLOC, 16'd8, 16'd0);
    push_word(OP_ALLOC, 16'd9, 16'd0);
    push_word(OP_ALLOC, 16'd2048, 16'd0);
    push_word(OP_ALLOC, 16'd0, 16'd0);
    push_word(OP_ALLOC, 16'd2049, 16'd0);
    push_word(OP_FREE, 16'hffff, 16'hffff);
    push_word(OP_FREE, 16'd8, 16'd48);                  // frame 0 slot 0
    push_word(OP_FREE, 16'd8, 16'd48);                  // second time: double free
    push_word(OP_FREE, 16'd8, 16'd8);                   // inside the header
    push_word(OP_FREE, 16'd8, 16'd51);                  // off a slot boundary
    push_word(OP_FREE, 16'd16, 16'd56);                 // frame of another class
    push_word(OP_FREE, 16'd2048, 16'(2 * 4096 + 48 + 2048)); // past the last slot
    push_word(OP_FREE, 16'd8, 16'hfff0);                // frame not in use
    push_word(OP_FREE, 16'd2048, 16'(2 * 4096 + 48));
    push_word(OP_NONE, 16'hffff, 16'hffff);
    push_word(OP_SHRINK, 16'd0, 16'd0);
    for (int i = 0; i < 5; i++) push_word(OP_ALLOC, 16'd2000, 16'd0);
    for (int i = 0; i < 5; i++) push_word(OP_FREE, 16'd2000, 16'(4096 * (i + 2) + 48));
    push_word(OP_SHRINK, 16'hffff, 16'hffff);
    pending_words.push_back('{op: OP_NONE, size: '0, address: '0, drain: 1'b1});

    for (int n = 0; n < 1100; n++) begin
      if (n % 250 == 249)
        pending_words.push_back('{op: OP_NONE, size: '0, address: '0, drain: 1'b1});
      p = $urandom_range(0, 99);
      if (p < 45) begin
        // large classes fill frames fast, small ones cost long stack builds
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        push_word(OP_ALLOC, size_in_class(c), 16'($urandom));
      end else if (p < 83 && live_addr.size() > 0) begin
        k = $urandom_range(0, live_addr.size() - 1);
        a = live_addr[k];
        s = live_size[k];
        c = 0;
        while ((8 << c) < s) c++;
        push_word(OP_FREE, size_in_class(c), a);
      end else if (p < 88 && gone_addr.size() > 0) begin
        k = $urandom_range(0, gone_addr.size() - 1);
        push_word(OP_FREE, gone_size[k], gone_addr[k]);
      end else if (p < 95) begin
        push_word(2'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        push_word(OP_SHRINK, 16'($urandom), 16'($urandom));
      end
    end

    wait (pending_words.size() == 0 && expected_rsps.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0 && !rsp.valid) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
